FILE: src/lcv_pkg.sv
// Package with the shared constants, types and helper function of the card number validator.
package lcv_pkg;

	// Number of decimal digits examined, and the width of one card number.
	localparam int DIGIT_COUNT = 16;
	localparam int CARD_W      = 54;

	// Full width used for the decimal weights, enough for ten to the eighteenth.
	localparam int WIDE_W = 64;

	// Issuer classes reported for a passing number.
	typedef enum logic [1:0] {
		TYPE_NONE  = 2'd0,
		TYPE_PFX3X = 2'd1,
		TYPE_PFX5X = 2'd2,
		TYPE_PFX4  = 2'd3
	} card_type_t;

	// Fixed per-cell settings, tied to constants by the top level.
	typedef struct packed {
		logic [WIDE_W-1:0] weight;   // decimal weight of the digit this cell extracts
		logic              odd;      // digit is doubled in the Luhn sum
		logic              cap_en;   // digit is one of the four leading digits used for prefixes
		logic [1:0]        cap_sel;  // which leading digit slot (position minus twelve)
		logic              hi;       // digit lies at position sixteen or above
	} cell_cfg_t;

	// Data carried along the row of cells with each request.
	typedef struct packed {
		logic              in_range;  // number is below ten to the DIGIT_COUNT
		logic [CARD_W-1:0] rem;       // part of the number not yet split into digits
		logic [3:0]        sum;       // Luhn digit sum so far, modulo ten
		logic [3:0][3:0]   lead;      // digits at positions twelve to fifteen
		logic              hi_nz;     // some digit at position sixteen or above is nonzero
	} cell_data_t;

	// Power of ten, evaluated at elaboration only.
	function automatic logic [WIDE_W-1:0] pow10(input int p);
		logic [WIDE_W-1:0] r;
		r = WIDE_W'(1);
		for (int k = 0; k < p; k++) begin
			r = r * WIDE_W'(10);
		end
		return r;
	endfunction

endpackage

FILE: src/lcv_if.sv
// Handshake interfaces for the card number requests and the check results.
interface lcv_card_if;
	import lcv_pkg::*;
	logic              valid;
	logic              ready;
	logic [CARD_W-1:0] card_number;

	modport source (output valid, output card_number, input ready);
	modport sink (input valid, input card_number, output ready);
endinterface

interface lcv_result_if;
	logic       valid;
	logic       ready;
	logic       checksum_ok;
	logic [1:0] card_type;

	modport source (output valid, output checksum_ok, output card_type, input ready);
	modport sink (input valid, input checksum_ok, input card_type, output ready);
endinterface

FILE: src/lcv_cell.sv
// One cell of the row: extracts one decimal digit and folds it into the Luhn sum.
module lcv_cell
	import lcv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cfg_t  cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  cell_data_t in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output cell_data_t out_data
);

	logic              v_q;
	cell_data_t        data_q;
	cell_data_t        data_n;
	logic [WIDE_W-1:0] r_wide;
	logic [WIDE_W-1:0] m1, m2, m3, m4, m5, m6, m7, m8, m9;
	logic [WIDE_W-1:0] sub;
	logic [3:0]        dig;
	logic [4:0]        dbl;
	logic [3:0]        dl;
	logic [4:0]        s;

	// Multiples of the weight, built from shifts, adds and one subtraction of a constant.
	always_comb begin
		m1 = cfg.weight;
		m2 = cfg.weight << 1;
		m4 = cfg.weight << 2;
		m8 = cfg.weight << 3;
		m3 = m2 + m1;
		m5 = m4 + m1;
		m6 = m4 + m2;
		m7 = m8 - m1;
		m9 = m8 + m1;
	end

	// Digit selection: the largest multiple that still fits in the remainder.
	always_comb begin
		r_wide = {{(WIDE_W-CARD_W){1'b0}}, in_data.rem};
		priority if (r_wide >= m9) begin
			dig = 4'd9; sub = m9;
		end else if (r_wide >= m8) begin
			dig = 4'd8; sub = m8;
		end else if (r_wide >= m7) begin
			dig = 4'd7; sub = m7;
		end else if (r_wide >= m6) begin
			dig = 4'd6; sub = m6;
		end else if (r_wide >= m5) begin
			dig = 4'd5; sub = m5;
		end else if (r_wide >= m4) begin
			dig = 4'd4; sub = m4;
		end else if (r_wide >= m3) begin
			dig = 4'd3; sub = m3;
		end else if (r_wide >= m2) begin
			dig = 4'd2; sub = m2;
		end else if (r_wide >= m1) begin
			dig = 4'd1; sub = m1;
		end else begin
			dig = 4'd0; sub = '0;
		end
	end

	// Luhn contribution of the digit, the running sum modulo ten, and the new remainder, leading digits and high flag.
	always_comb begin
		dbl = {dig, 1'b0};
		if (cfg.odd) begin
			dl = (dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0];
		end else begin
			dl = dig;
		end
		s = {1'b0, in_data.sum} + {1'b0, dl};

		data_n          = in_data;
		data_n.rem      = CARD_W'(r_wide - sub);
		data_n.sum      = (s >= 5'd10) ? 4'(s - 5'd10) : s[3:0];
		if (cfg.cap_en) begin
			data_n.lead[cfg.cap_sel] = dig;
		end
		data_n.hi_nz    = in_data.hi_nz | (cfg.hi & (dig != 4'd0));
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data  = data_q;

	// Stage register: takes a new request whenever it is empty or the next cell can drain this one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_q <= 1'b1;
		end else if (out_ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= data_n;
		end
	end

	// Remainder of an in-range number stays below this cell's weight.
	a_rem_below_weight: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && data_q.in_range |-> {{(WIDE_W-CARD_W){1'b0}}, data_q.rem} < cfg.weight)
		else $error("remainder not below cell weight");

	// Running sum is always a decimal digit.
	a_sum_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> data_q.sum <= 4'd9)
		else $error("Luhn sum out of range");

	// A taken request is held in the cell on the next cycle.
	a_take_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_q)
		else $error("accepted request lost");

endmodule

FILE: src/luhn_card_number_validator_top.sv
// Stages: one entry register, one cell per digit, one result register.
// Throughput: one request per cycle while the result channel does not stall.
// Each digit cell compares its remainder against nine multiples of its decimal weight.
// A full result register holds back only the stages behind it; bubbles still close up.
// Reset (arst_n low, asynchronous) clears every stage valid flag; data registers are not reset.
module luhn_card_number_validator_top
	import lcv_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	lcv_card_if.sink     card,
	lcv_result_if.source result
);

	localparam logic [WIDE_W-1:0] LIMIT = pow10(DIGIT_COUNT);

	logic       stg_v   [DIGIT_COUNT+1];
	logic       stg_rdy [DIGIT_COUNT+1];
	cell_data_t stg_d   [DIGIT_COUNT+1];

	logic       ent_v_q;
	cell_data_t ent_q;
	logic       res_v_q;
	logic       res_ok_q;
	card_type_t res_type_q;
	logic       res_take;
	cell_data_t last;
	logic       ok;
	logic       t3x, t5x, t4;
	card_type_t ctype;

	// Entry stage: range check and start values of the digit sweep.
	assign card.ready = !ent_v_q || stg_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_v_q <= 1'b0;
		end else if (card.valid && card.ready) begin
			ent_v_q <= 1'b1;
		end else if (stg_rdy[0]) begin
			ent_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (card.valid && card.ready) begin
			ent_q.in_range <= {{(WIDE_W-CARD_W){1'b0}}, card.card_number} < LIMIT;
			ent_q.rem      <= card.card_number;
			ent_q.sum      <= '0;
			ent_q.lead     <= '0;
			ent_q.hi_nz    <= 1'b0;
		end
	end

	assign stg_v[0] = ent_v_q;
	assign stg_d[0] = ent_q;

	// Row of digit cells, most significant position first.
	for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
		localparam int POS = DIGIT_COUNT - 1 - i;
		cell_cfg_t cfg;

		assign cfg.weight  = pow10(POS);
		assign cfg.odd     = 1'((POS % 2) == 1);
		assign cfg.cap_en  = 1'((POS >= 12) && (POS <= 15));
		assign cfg.cap_sel = 2'(POS - 12);
		assign cfg.hi      = 1'(POS >= 16);

		lcv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.in_valid  (stg_v[i]),
			.in_ready  (stg_rdy[i]),
			.in_data   (stg_d[i]),
			.out_valid (stg_v[i+1]),
			.out_ready (stg_rdy[i+1]),
			.out_data  (stg_d[i+1])
		);
	end

	// Prefix classification from the captured leading digits.
	always_comb begin
		last = stg_d[DIGIT_COUNT];
		ok   = last.in_range && (last.sum == 4'd0);
		t3x  = !last.hi_nz && (last.lead[3] == 4'd0) && (last.lead[2] == 4'd3)
			&& ((last.lead[1] == 4'd4) || (last.lead[1] == 4'd7));
		t5x  = !last.hi_nz && (last.lead[3] == 4'd5)
			&& (last.lead[2] >= 4'd1) && (last.lead[2] <= 4'd5);
		t4   = !last.hi_nz && ((last.lead[3] == 4'd4)
			|| ((last.lead[3] == 4'd0) && (last.lead[2] == 4'd0)
			&& (last.lead[1] == 4'd0) && (last.lead[0] == 4'd4)));
		priority if (!ok) begin
			ctype = TYPE_NONE;
		end else if (t3x) begin
			ctype = TYPE_PFX3X;
		end else if (t5x) begin
			ctype = TYPE_PFX5X;
		end else if (t4) begin
			ctype = TYPE_PFX4;
		end else begin
			ctype = TYPE_NONE;
		end
	end

	// Result register facing the output channel.
	assign stg_rdy[DIGIT_COUNT] = !res_v_q || result.ready;
	assign res_take             = stg_v[DIGIT_COUNT] && stg_rdy[DIGIT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (res_take) begin
			res_v_q <= 1'b1;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			res_ok_q   <= ok;
			res_type_q <= ctype;
		end
	end

	assign result.valid       = res_v_q;
	assign result.checksum_ok = res_ok_q;
	assign result.card_type   = res_type_q;

	// A classified number must have passed the checksum.
	a_type_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && (res_type_q != TYPE_NONE) |-> res_ok_q)
		else $error("card type reported for a failing number");

	// An out-of-range number never passes.
	a_range_fails: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && !last.in_range |=> !res_ok_q)
		else $error("out-of-range number reported as passing");

	// Input is held off only while the entry stage is occupied.
	a_ready_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!card.ready |-> ent_v_q)
		else $error("input stalled with empty entry stage");

endmodule

FILE: tb/tb_luhn_card_number_validator_top.sv
// Self-checking testbench for the Luhn card number validator: randomised requests against a local predictor.
`timescale 1ns / 100ps

module tb_luhn_card_number_validator_top;
	import lcv_pkg::*;

	// Expected outcome of one request, kept with its card number for reporting.
	typedef struct {
		logic [CARD_W-1:0] number;
		logic              checksum_ok;
		card_type_t        card_type;
	} card_check_t;

	// Numbers at or above this bound have too many digits and are rejected.
	localparam logic [63:0] DIGIT_LIMIT = 64'd10 ** DIGIT_COUNT;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lcv_card_if   card_bus ();
	lcv_result_if result_bus ();

	luhn_card_number_validator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.card   (card_bus),
		.result (result_bus)
	);

	logic [CARD_W-1:0] pending_cards[$];
	card_check_t       expected_checks[$];
	int                card_total;
	int                cards_offered;
	int                cards_taken;
	int                results_seen;
	int                results_noted;
	int                gap_left;
	int                stall_left;
	int                mismatch_count;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Luhn digit sum over the examined digits, every second one from the right doubled.
	function automatic int unsigned luhn_total(input logic [63:0] num);
		int unsigned total;
		int unsigned d;
		total = 0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			d = int'(num % 64'd10);
			num = num / 64'd10;
			if (i % 2 == 1) begin
				d = d * 2;
				if (d >= 10)
					d = d - 9;
			end
			total = total + d;
		end
		return total;
	endfunction

	// Predicts the checksum flag and the issuer class for one card number.
	function automatic card_check_t check_card(input logic [CARD_W-1:0] number);
		card_check_t res;
		logic [63:0] num;
		logic [63:0] lead15;
		logic [63:0] lead16;
		num = 64'(number);
		res.number = number;
		res.checksum_ok = 1'b0;
		res.card_type = TYPE_NONE;
		if (num < DIGIT_LIMIT) begin
			res.checksum_ok = (luhn_total(num) % 10 == 0);
			if (res.checksum_ok) begin
				lead15 = num / 64'd10_000_000_000_000;
				lead16 = num / 64'd100_000_000_000_000;
				// The prefix tests go in a fixed order and the first match wins.
				if (lead15 == 64'd34 || lead15 == 64'd37)
					res.card_type = TYPE_PFX3X;
				else if (lead16 >= 64'd51 && lead16 <= 64'd55)
					res.card_type = TYPE_PFX5X;
				else if (num / 64'd1_000_000_000_000 == 64'd4 ||
						num / 64'd1_000_000_000_000_000 == 64'd4)
					res.card_type = TYPE_PFX4;
			end
		end
		return res;
	endfunction

	function automatic logic [63:0] rand_below(input logic [63:0] bound);
		return {$urandom, $urandom} % bound;
	endfunction

	// Replaces the last digit so that the Luhn sum becomes a multiple of ten.
	function automatic logic [63:0] with_check_digit(input logic [63:0] num);
		logic [63:0] base;
		base = num - num % 64'd10;
		return base + 64'((10 - luhn_total(base) % 10) % 10);
	endfunction

	// Moves the last digit by one, which always breaks a passing checksum.
	function automatic logic [63:0] bad_check_digit(input logic [63:0] num);
		return num - num % 64'd10 + (num % 64'd10 + 64'd1) % 64'd10;
	endfunction

	// A passing number of the given length that begins with the given prefix.
	function automatic logic [63:0] make_card(input int unsigned prefix, input int prefix_digits,
			input int length);
		logic [63:0] scale;
		scale = 64'd10 ** (length - prefix_digits);
		return with_check_digit(64'(prefix) * scale + rand_below(scale));
	endfunction

	// Request driver: one card number at a time, with a random gap after each request except in stretches with none.
	always @(negedge clk) begin : card_driver
		if (arst_n) begin
			if (!card_bus.valid || cards_taken == cards_offered) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					card_bus.valid <= 1'b0;
				end else if (pending_cards.size() > 0) begin
					card_bus.card_number <= pending_cards.pop_front();
					card_bus.valid <= 1'b1;
					cards_offered <= cards_offered + 1;
					gap_left <= ((cards_offered % 300) >= 230) ? 0 : $urandom_range(0, 3);
				end else begin
					card_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result sink: after each result it may hold ready low for a random stall, except in stretches where it stays ready.
	always @(negedge clk) begin : result_sink
		int nstall;
		if (arst_n) begin
			if (results_seen != results_noted) begin
				results_noted <= results_seen;
				nstall = ((results_seen % 300) >= 230) ? 0 : $urandom_range(0, 3);
				if (nstall == 0) begin
					result_bus.ready <= 1'b1;
				end else begin
					result_bus.ready <= 1'b0;
					stall_left <= nstall - 1;
				end
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Records accepted requests with their predicted outcome and checks each result in order.
	always @(posedge clk) begin : result_monitor
		card_check_t want;
		if (arst_n) begin
			if (card_bus.valid && card_bus.ready) begin
				expected_checks.push_back(check_card(card_bus.card_number));
				cards_taken <= cards_taken + 1;
			end
			if (result_bus.valid && result_bus.ready) begin
				results_seen <= results_seen + 1;
				if (expected_checks.size() == 0) begin
					$display("%0t: unexpected result, checksum_ok %0b card_type %0d", $time,
						result_bus.checksum_ok, result_bus.card_type);
					mismatch_count++;
				end else begin
					want = expected_checks.pop_front();
					if (result_bus.checksum_ok !== want.checksum_ok) begin
						$display("%0t: card %0d checksum_ok expected %0b, got %0b", $time,
							want.number, want.checksum_ok, result_bus.checksum_ok);
						mismatch_count++;
					end
					if (result_bus.card_type !== want.card_type) begin
						$display("%0t: card %0d card_type expected %0d, got %0d", $time,
							want.number, want.card_type, result_bus.card_type);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		logic [63:0] num;
		int kind;
		int sel;
		card_bus.valid = 1'b0;
		card_bus.card_number = '0;
		result_bus.ready = 1'b0;

		// Directed requests: field extremes, each issuer class, near misses and rejected widths.
		pending_cards.push_back(CARD_W'(0));
		pending_cards.push_back({CARD_W{1'b1}});
		pending_cards.push_back(CARD_W'(DIGIT_LIMIT - 64'd1));
		pending_cards.push_back(CARD_W'(DIGIT_LIMIT));
		pending_cards.push_back(CARD_W'(DIGIT_LIMIT + 64'd8));
		pending_cards.push_back(CARD_W'(with_check_digit(DIGIT_LIMIT - 64'd10)));
		pending_cards.push_back(CARD_W'(18));
		pending_cards.push_back(CARD_W'(make_card(34, 2, 15)));
		pending_cards.push_back(CARD_W'(make_card(37, 2, 15)));
		pending_cards.push_back(CARD_W'(make_card(51, 2, 16)));
		pending_cards.push_back(CARD_W'(make_card(53, 2, 16)));
		pending_cards.push_back(CARD_W'(make_card(55, 2, 16)));
		pending_cards.push_back(CARD_W'(make_card(4, 1, 13)));
		pending_cards.push_back(CARD_W'(make_card(4, 1, 16)));
		pending_cards.push_back(CARD_W'(bad_check_digit(make_card(37, 2, 15))));
		pending_cards.push_back(CARD_W'(bad_check_digit(make_card(52, 2, 16))));
		pending_cards.push_back(CARD_W'(bad_check_digit(make_card(4, 1, 13))));
		pending_cards.push_back(CARD_W'(make_card(35, 2, 15)));
		pending_cards.push_back(CARD_W'(make_card(34, 2, 16)));
		pending_cards.push_back(CARD_W'(make_card(50, 2, 16)));
		pending_cards.push_back(CARD_W'(make_card(56, 2, 16)));
		pending_cards.push_back(CARD_W'(make_card(4, 1, 14)));
		pending_cards.push_back(CARD_W'(make_card(4, 1, 15)));
		pending_cards.push_back(CARD_W'(make_card(9, 1, 16)));

		// Random requests, half of them built as card numbers with random digits.
		repeat (950) begin
			kind = $urandom_range(0, 9);
			if (kind <= 4) begin
				sel = $urandom_range(0, 5);
				case (sel)
					0: num = make_card($urandom_range(0, 1) ? 37 : 34, 2, 15);
					1: num = make_card($urandom_range(51, 55), 2, 16);
					2: num = make_card(4, 1, 13);
					3: num = make_card(4, 1, 16);
					4: num = make_card($urandom_range(10, 99), 2, $urandom_range(13, 16));
					default: num = make_card($urandom_range(1, 9), 1, $urandom_range(2, DIGIT_COUNT));
				endcase
				if ($urandom_range(0, 7) == 0)
					num = bad_check_digit(num);
			end else if (kind <= 6) begin
				num = rand_below(64'd10 ** $urandom_range(1, DIGIT_COUNT));
				if ($urandom_range(0, 1))
					num = with_check_digit(num);
			end else if (kind == 7) begin
				num = {$urandom, $urandom};
			end else if (kind == 8) begin
				if ($urandom_range(0, 1))
					num = DIGIT_LIMIT - 64'd1 - 64'($urandom_range(0, 99));
				else
					num = DIGIT_LIMIT + 64'($urandom_range(0, 99));
			end else begin
				num = rand_below(DIGIT_LIMIT);
			end
			pending_cards.push_back(CARD_W'(num));
		end
		card_total = pending_cards.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: every request taken, every result returned, then a pipeline's worth of quiet.
		while (cards_taken != card_total)
			@(posedge clk);
		while (expected_checks.size() != 0)
			@(posedge clk);
		repeat (DIGIT_COUNT + 10) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("luhn_card_number_validator_top test passed");
		end else begin
			$display("luhn_card_number_validator_top test failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#2_000_000;
		$display("luhn_card_number_validator_top test failed");
		$finish;
	end

endmodule

FILE: files.f
src/lcv_pkg.sv
src/lcv_if.sv
src/lcv_cell.sv
src/luhn_card_number_validator_top.sv
tb/tb_luhn_card_number_validator_top.sv
